// ===== hdl/assert_macros.svh =====
// Assertion macros for the lens stepper checker.
// Every macro expects i_clk and i_rst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold on every clock edge out of reset.
`define CHK_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("lens stepper check failed");

// Same-cycle implication.
`define CHK_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lens stepper check failed");

// Next-cycle implication.
`define CHK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lens stepper check failed");

`endif

// ===== hdl/lsms_pkg.sv =====
// Shared types and constants for the lens stepper move sequencer.
// No dependencies; used by the top level and its checker.
package lsms_pkg;

    localparam int CMD_W   = 2;
    localparam int SPEED_W = 16;
    localparam int RATE_W  = 16;
    localparam int STEP_W  = 7;
    localparam int POS_W   = 32;

    localparam logic [CMD_W-1:0] CMD_START = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_STOP  = 2'd2;

    // Rate word numerator: clocks per frame, and its width for the divider.
    localparam int                DIV_W           = 21;
    localparam logic [DIV_W-1:0]  CLOCK_PER_FRAME = 21'd1687500;
    localparam int                RATE_DIV        = 24;

    // speed / 8 pulses per unit, then / 16 frames per second
    localparam int PULSE_SHIFT = 3;
    localparam int FRAME_SHIFT = 4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_WRITE
    } t_state;

endpackage

// ===== hdl/lens_stepper_move_sequencer.sv =====
// Lens stepper move sequencer: one axis, chunked moves, bit-serial rate divider.
// Depends on lsms_pkg.
//
// Usage:
//   Input channel (i_valid / o_stall) takes one request: start, frame tick or
//   stop, with speed and signed distance. Output channel (o_valid / i_stall)
//   returns exactly one result per request: status, rate word, step count,
//   direction, step word flag, busy, last chunk flag and position.
// Sequencing:
//   A stop, rejected start, idle or closing tick, full-chunk tick or unused
//   command skips the divider and is written out. A start, or a tick that
//   issues the remainder chunk, first runs the shared restoring divider, one
//   quotient bit per cycle over DIV_W (21) bits. One request is in flight at once.
// Reset:
//   Synchronous, active low. Axis idle, direction clockwise, chunk 1, rate
//   word 0, position 0, no result pending.
// Receiver stall:
//   The result holds in the output register. One further request is accepted
//   and worked out, then waits until the output register frees up; the axis
//   state is updated only when its result is written.
module lens_stepper_move_sequencer #(
    parameter int CHUNK_MAX       = 127,
    parameter int MICRO_PER_UNIT  = 32,
    parameter int MICRO_PER_COUNT = 8,
    parameter int DISTANCE_BITS   = 21
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [lsms_pkg::CMD_W-1:0]          i_command,
    input  logic [lsms_pkg::SPEED_W-1:0]        i_speed_pps,
    input  logic signed [DISTANCE_BITS-1:0]     i_move_distance,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_status,
    output logic [lsms_pkg::RATE_W-1:0]         o_rate_word,
    output logic [lsms_pkg::STEP_W-1:0]         o_step_count,
    output logic                                o_counter_clockwise,
    output logic                                o_step_word_valid,
    output logic                                o_busy_res,
    output logic                                o_last_chunk,
    output logic signed [lsms_pkg::POS_W-1:0]   o_position
);
    import lsms_pkg::*;

    localparam int MAG_W    = DISTANCE_BITS - 1;
    localparam int REM_W    = MAG_W + $clog2(MICRO_PER_UNIT);
    localparam int SCALED_W = SPEED_W - PULSE_SHIFT + $clog2(MICRO_PER_UNIT + 1);
    localparam int RAWC_W   = SCALED_W - FRAME_SHIFT;
    localparam int PC_W     = $clog2(CHUNK_MAX * MICRO_PER_COUNT + 1);
    localparam int SUM_W    = REM_W + PC_W;
    localparam int DVS_MAX  = (CHUNK_MAX * RATE_DIV > MICRO_PER_COUNT) ?
                              CHUNK_MAX * RATE_DIV : MICRO_PER_COUNT;
    localparam int DVS_W    = $clog2(DVS_MAX + 1);
    localparam int CNT_W    = $clog2(DIV_W);

    t_state r_state, n_state;

    // axis state
    logic                r_moving;
    logic                r_reverse;
    logic [STEP_W-1:0]   r_chunk;
    logic [REM_W-1:0]    r_remain;
    logic [POS_W-1:0]    r_pos;
    logic [RATE_W-1:0]   r_rate;

    // latched request
    logic [CMD_W-1:0]    r_cmd;
    logic [STEP_W-1:0]   r_chunk_new;
    logic                r_neg_new;
    logic [MAG_W-1:0]    r_mag_new;
    logic                r_zero;

    // serial divider
    logic [DVS_W-1:0]    r_div_rem;
    logic [DIV_W-1:0]    r_div_quo;
    logic [DVS_W-1:0]    r_div_dvs;
    logic [CNT_W-1:0]    r_div_cnt;

    // result payload
    logic                r_out_valid;
    logic                r_status;
    logic [STEP_W-1:0]   r_steps;
    logic                r_word_valid;
    logic                r_last;

    logic w_accept, w_write, w_need_div;

    // ---- chunk size from speed ----
    logic [SCALED_W-1:0] w_scaled;
    logic [RAWC_W-1:0]   w_chunk_raw;
    logic [STEP_W-1:0]   w_chunk;

    assign w_scaled    = SCALED_W'(MICRO_PER_UNIT) * SCALED_W'(i_speed_pps >> PULSE_SHIFT);
    assign w_chunk_raw = w_scaled[SCALED_W-1:FRAME_SHIFT];

    always_comb begin
        if (w_chunk_raw == '0) begin
            w_chunk = STEP_W'(1);
        end else if (w_chunk_raw > RAWC_W'(CHUNK_MAX)) begin
            w_chunk = STEP_W'(CHUNK_MAX);
        end else begin
            w_chunk = w_chunk_raw[STEP_W-1:0];
        end
    end

    // ---- distance magnitude, most negative saturates ----
    logic [DISTANCE_BITS-1:0] w_dist_u, w_abs;
    logic [MAG_W-1:0]         w_mag;
    logic                     w_neg, w_dist_zero;

    assign w_dist_u    = $unsigned(i_move_distance);
    assign w_neg       = w_dist_u[DISTANCE_BITS-1];
    assign w_abs       = w_neg ? (~w_dist_u + 1'b1) : w_dist_u;
    assign w_mag       = w_abs[DISTANCE_BITS-1] ? '1 : w_abs[MAG_W-1:0];
    assign w_dist_zero = (w_dist_u == '0);

    // ---- tick decision from current axis state ----
    logic [PC_W-1:0]  w_per_chunk;
    logic [SUM_W-1:0] w_remain_ext;
    logic             w_full, w_has_rest;

    assign w_per_chunk  = PC_W'(r_chunk * MICRO_PER_COUNT);
    assign w_remain_ext = SUM_W'(r_remain);
    assign w_full       = w_remain_ext >= SUM_W'(w_per_chunk);
    assign w_has_rest   = w_remain_ext >= SUM_W'(MICRO_PER_COUNT);

    assign w_need_div = ((i_command == CMD_START) && !w_dist_zero) ||
                        ((i_command == CMD_TICK) && r_moving && !w_full && w_has_rest);

    // ---- restoring divider step ----
    logic [DVS_W:0] w_trial, w_diff;
    logic           w_ge;

    assign w_trial = {r_div_rem, r_div_quo[DIV_W-1]};
    assign w_diff  = w_trial - {1'b0, r_div_dvs};
    assign w_ge    = w_trial >= {1'b0, r_div_dvs};

    // ---- control ----
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = w_need_div ? ST_DIV : ST_WRITE;
                end
            end
            ST_DIV: begin
                if (r_div_cnt == '0) begin
                    n_state = ST_WRITE;
                end
            end
            ST_WRITE: begin
                if (!r_out_valid || !i_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_stall  = (r_state != ST_IDLE);
        w_accept = (r_state == ST_IDLE) && i_valid;
        w_write  = (r_state == ST_WRITE) && (!r_out_valid || !i_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_moving    <= 1'b0;
            r_reverse   <= 1'b0;
            r_chunk     <= STEP_W'(1);
            r_remain    <= '0;
            r_pos       <= '0;
            r_rate      <= '0;
        end else begin
            r_state <= n_state;
            if (w_write) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end

            if (w_write) begin
                case (r_cmd)
                    CMD_START: begin
                        if (!r_zero) begin
                            r_chunk   <= r_chunk_new;
                            r_rate    <= r_div_quo[RATE_W-1:0];
                            r_reverse <= r_neg_new;
                            r_remain  <= REM_W'(r_mag_new) * REM_W'(MICRO_PER_UNIT);
                            r_moving  <= 1'b1;
                        end
                    end
                    CMD_TICK: begin
                        if (r_moving) begin
                            if (w_full) begin
                                r_remain <= r_remain - REM_W'(w_per_chunk);
                                r_pos    <= r_reverse ? r_pos - 1'b1 : r_pos + 1'b1;
                            end else if (w_has_rest) begin
                                r_remain <= '0;
                                r_pos    <= r_reverse ? r_pos - 1'b1 : r_pos + 1'b1;
                            end else begin
                                r_remain <= '0;
                                r_moving <= 1'b0;
                            end
                        end
                    end
                    CMD_STOP: begin
                        r_moving <= 1'b0;
                        r_remain <= '0;
                    end
                    default: ;
                endcase
            end
        end
    end

    // request latch, divider and result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd       <= i_command;
            r_chunk_new <= w_chunk;
            r_neg_new   <= w_neg;
            r_mag_new   <= w_mag;
            r_zero      <= w_dist_zero;
            r_div_rem   <= '0;
            r_div_cnt   <= CNT_W'(DIV_W - 1);
            if (i_command == CMD_START) begin
                r_div_quo <= CLOCK_PER_FRAME;
                r_div_dvs <= DVS_W'(w_chunk * RATE_DIV);
            end else begin
                // remainder chunk: remaining is below one full chunk here
                r_div_quo <= DIV_W'(w_remain_ext[PC_W-1:0]);
                r_div_dvs <= DVS_W'(MICRO_PER_COUNT);
            end
        end else if (r_state == ST_DIV) begin
            r_div_rem <= w_ge ? w_diff[DVS_W-1:0] : w_trial[DVS_W-1:0];
            r_div_quo <= {r_div_quo[DIV_W-2:0], w_ge};
            r_div_cnt <= r_div_cnt - 1'b1;
        end

        if (w_write) begin
            r_status     <= 1'b0;
            r_steps      <= '0;
            r_word_valid <= 1'b0;
            r_last       <= 1'b0;
            case (r_cmd)
                CMD_START: begin
                    r_status <= r_zero;
                end
                CMD_TICK: begin
                    if (r_moving) begin
                        r_word_valid <= 1'b1;
                        if (w_full) begin
                            r_steps <= r_chunk;
                        end else if (w_has_rest) begin
                            r_steps <= r_div_quo[STEP_W-1:0];
                        end else begin
                            r_last <= 1'b1;
                        end
                    end
                end
                CMD_STOP: begin
                    r_word_valid <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // axis state is written together with its result, so it holds under stall
    assign o_valid             = r_out_valid;
    assign o_status            = r_status;
    assign o_rate_word         = r_rate;
    assign o_step_count        = r_steps;
    assign o_counter_clockwise = r_reverse;
    assign o_step_word_valid   = r_word_valid;
    assign o_busy_res          = r_moving;
    assign o_last_chunk        = r_last;
    assign o_position          = $signed(r_pos);

endmodule

// ===== hdl/lsms_checker.sv =====
// Port-level checks for the lens stepper move sequencer, bound to the top level.
// Depends on lsms_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lsms_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_valid,
    input logic                              i_stall,
    input logic                              o_status,
    input logic [lsms_pkg::STEP_W-1:0]       o_step_count,
    input logic                              o_step_word_valid,
    input logic                              o_busy_res,
    input logic                              o_last_chunk,
    input logic signed [lsms_pkg::POS_W-1:0] o_position
);
    import lsms_pkg::*;

    // a non-zero step count comes only with a step word that is not the last
    `CHK_IMPL(a_steps_in_word, o_valid && (o_step_count != '0), o_step_word_valid && !o_last_chunk && !o_status)

    // the closing word carries no steps and leaves the axis idle
    `CHK_IMPL(a_last_ends_move, o_valid && o_last_chunk, o_step_word_valid && !o_busy_res && (o_step_count == '0))

    // a rejected start issues no step word
    `CHK_ALWAYS(a_reject_no_word, !(o_valid && o_status) || !o_step_word_valid)

    // a stalled result keeps its position
    `CHK_NEXT(a_stall_holds, o_valid && i_stall, o_valid && $stable(o_position))

endmodule

bind lens_stepper_move_sequencer lsms_checker u_lsms_checker (.*);

// ===== verif/tb.sv =====
// Self-checking testbench for the lens stepper move sequencer: directed and random
// bursts of start, tick, stop and unused requests are checked by an axis predictor.
// Depends on lsms_pkg and lens_stepper_move_sequencer.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lsms_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int DIST_W     = 21;
    localparam int CHUNK_TOP  = 127;
    localparam int N_RANDOM   = 1900;
    localparam int CYCLE_CAP  = 600000;
    localparam int HOLD_START = 2000;
    localparam int HOLD_LEN   = 300;
    localparam int DRAIN_WAIT = 40;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [SPEED_W-1:0] speed;
        logic [DIST_W-1:0]  distance;
    } move_req_t;

    typedef struct packed {
        logic               status;
        logic [RATE_W-1:0]  rate;
        logic [STEP_W-1:0]  steps;
        logic               ccw;
        logic               word_valid;
        logic               busy;
        logic               last;
        logic [POS_W-1:0]   pos;
    } step_result_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    logic [CMD_W-1:0] i_command = '0;
    logic [SPEED_W-1:0] i_speed_pps = '0;
    logic signed [DIST_W-1:0] i_move_distance = '0;
    logic o_stall, o_valid, o_status, o_counter_clockwise, o_step_word_valid;
    logic o_busy_res, o_last_chunk;
    logic [RATE_W-1:0] o_rate_word;
    logic [STEP_W-1:0] o_step_count;
    logic signed [POS_W-1:0] o_position;

    lens_stepper_move_sequencer uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_command           (i_command),
        .i_speed_pps         (i_speed_pps),
        .i_move_distance     (i_move_distance),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_status            (o_status),
        .o_rate_word         (o_rate_word),
        .o_step_count        (o_step_count),
        .o_counter_clockwise (o_counter_clockwise),
        .o_step_word_valid   (o_step_word_valid),
        .o_busy_res          (o_busy_res),
        .o_last_chunk        (o_last_chunk),
        .o_position          (o_position)
    );

    // Axis copy held by the predictor, at its reset values.
    logic              ax_moving = 1'b0;
    logic              ax_reverse = 1'b0;
    logic [6:0]        ax_chunk = 7'd1;
    logic [25:0]       ax_remaining = '0;
    logic [POS_W-1:0]  ax_position = '0;
    logic [RATE_W-1:0] ax_rate = '0;

    move_req_t    pending_reqs[$];
    step_result_t expected_steps[$];
    move_req_t    offered;
    int errors = 0;
    int burst_left = 1;
    int gap_left = 0;
    int cycle_count = 0;
    int rx_cycle = 0;
    int hold_left = 0;
    int pace_mode = 0;
    int pace_left = 0;
    logic stall_next;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic int chunk_for(input logic [SPEED_W-1:0] speed);
        int c;
        c = (32 * (int'(speed) >> 3)) / 16;
        if (c < 1) c = 1;
        if (c > CHUNK_TOP) c = CHUNK_TOP;
        return c;
    endfunction

    function automatic step_result_t predict_axis(input move_req_t r);
        step_result_t e;
        logic [DIST_W-1:0] mag;
        logic [25:0] per_chunk;
        logic [25:0] rest;
        e = '0;
        case (r.cmd)
            CMD_START: begin
                if (r.distance == '0) begin
                    e.status = 1'b1;
                end else begin
                    mag = r.distance[DIST_W-1] ? (~r.distance + 1'b1) : r.distance;
                    // saturate the sign-only pattern
                    if (mag > {1'b0, {(DIST_W-1){1'b1}}}) mag = {1'b0, {(DIST_W-1){1'b1}}};
                    ax_chunk = 7'(chunk_for(r.speed));
                    ax_rate = RATE_W'(int'(CLOCK_PER_FRAME) / (int'(ax_chunk) * RATE_DIV));
                    ax_reverse = r.distance[DIST_W-1];
                    ax_remaining = 26'(mag) << 5;
                    ax_moving = 1'b1;
                end
            end
            CMD_TICK: begin
                if (ax_moving) begin
                    per_chunk = 26'(ax_chunk) << 3;
                    rest = ax_remaining >> 3;
                    e.word_valid = 1'b1;
                    if (ax_remaining >= per_chunk) begin
                        e.steps = ax_chunk;
                        ax_remaining = ax_remaining - per_chunk;
                    end else if (rest != '0) begin
                        e.steps = rest[6:0];
                        ax_remaining = '0;
                    end else begin
                        e.last = 1'b1;
                        ax_moving = 1'b0;
                        ax_remaining = '0;
                    end
                    if (e.steps != '0) ax_position = ax_reverse ? ax_position - 1 : ax_position + 1;
                end
            end
            CMD_STOP: begin
                e.word_valid = 1'b1;
                ax_moving = 1'b0;
                ax_remaining = '0;
            end
            default: ;
        endcase
        e.rate = ax_rate;
        e.ccw = ax_reverse;
        e.busy = ax_moving;
        e.pos = ax_position;
        return e;
    endfunction

    task automatic add_req(input logic [CMD_W-1:0] c, input logic [SPEED_W-1:0] s,
                           input logic [DIST_W-1:0] d);
        move_req_t r;
        r.cmd = c;
        r.speed = s;
        r.distance = d;
        pending_reqs.push_back(r);
    endtask

    task automatic add_ticks(input int n);
        for (int k = 0; k < n; k++) begin
            // sprinkle the unused command as noise inside a move
            if ($urandom_range(0, 99) < 3) begin
                add_req(CMD_UNUSED, SPEED_W'($urandom), DIST_W'($urandom));
            end
            add_req(CMD_TICK, SPEED_W'($urandom), DIST_W'($urandom));
        end
    endtask

    task automatic build_directed();
        add_req(CMD_TICK, 16'hFFFF, 21'h1FFFFF);
        add_req(CMD_STOP, 16'h0, 21'h0);
        add_req(CMD_UNUSED, 16'hFFFF, 21'h1FFFFF);
        add_req(CMD_START, 16'hFFFF, 21'h0);
        // zero speed: chunk of one, four full chunks
        add_req(CMD_START, 16'h0, 21'd1);
        add_ticks(5);
        add_req(CMD_TICK, 16'h0, 21'h0);
        // chunk of six, a remainder word of four steps
        add_req(CMD_START, 16'd24, -21'sd1);
        add_ticks(2);
        add_req(CMD_START, 16'hFFFF, 21'hFFFFF);
        add_ticks(2);
        // start while busy, most negative distance
        add_req(CMD_START, 16'd7, 21'h100000);
        add_ticks(2);
        add_req(CMD_STOP, 16'hFFFF, 21'h1FFFFF);
        add_req(CMD_TICK, 16'h0, 21'h0);
        add_req(CMD_START, 16'd600, 21'd3);
        add_ticks(2);
    endtask

    task automatic build_random(input int target);
        int roll, mag, chunk, n, ending;
        logic [SPEED_W-1:0] spd;
        logic [DIST_W-1:0] d;
        while (pending_reqs.size() < target) begin
            roll = $urandom_range(0, 99);
            if (roll < 4) begin
                add_req(CMD_START, SPEED_W'($urandom), '0);
            end else if (roll < 7) begin
                add_req(CMD_STOP, SPEED_W'($urandom), DIST_W'($urandom));
            end else if (roll < 10) begin
                add_req($urandom_range(0, 1) ? CMD_UNUSED : CMD_TICK,
                        SPEED_W'($urandom), DIST_W'($urandom));
            end else begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: spd = SPEED_W'($urandom_range(0, 120));
                    4, 5, 6:    spd = SPEED_W'($urandom_range(0, 1023));
                    default:    spd = SPEED_W'($urandom);
                endcase
                chunk = chunk_for(spd);
                if ($urandom_range(0, 99) < 6) begin
                    // long move: a few chunks, then cut short
                    d = DIST_W'($urandom);
                    add_req(CMD_START, spd, d);
                    add_ticks($urandom_range(1, 6));
                    if ($urandom_range(0, 1)) begin
                        add_req(CMD_STOP, SPEED_W'($urandom), DIST_W'($urandom));
                    end
                end else begin
                    mag = $urandom_range(1, 24);
                    d = $urandom_range(0, 1) ? -DIST_W'(mag) : DIST_W'(mag);
                    add_req(CMD_START, spd, d);
                    n = (4 * mag + chunk - 1) / chunk + 1;
                    ending = $urandom_range(0, 9);
                    if (ending == 0) begin
                        add_ticks($urandom_range(0, n - 1));
                        add_req(CMD_STOP, SPEED_W'($urandom), DIST_W'($urandom));
                    end else if (ending == 1) begin
                        add_ticks($urandom_range(0, n - 1));
                    end else begin
                        add_ticks(n + $urandom_range(0, 2));
                    end
                end
            end
        end
    endtask

    task automatic cmp_field(input string fname, input logic [31:0] want, input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
            errors++;
        end
    endtask

    // Request driver: bursts of requests with random gaps, payload held while stalled.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                expected_steps.push_back(predict_axis(offered));
            end
            if (!(i_valid && o_stall)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    offered = pending_reqs.pop_front();
                    i_command <= offered.cmd;
                    i_speed_pps <= offered.speed;
                    i_move_distance <= offered.distance;
                    i_valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 20);
                        gap_left = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver pacing: one long hold, otherwise stall modes picked at random in turn.
    always @(posedge i_clk) begin
        rx_cycle++;
        stall_next = 1'b0;
        if (hold_left > 0) begin
            hold_left--;
            stall_next = 1'b1;
        end else if (rx_cycle == HOLD_START) begin
            hold_left = HOLD_LEN;
            stall_next = 1'b1;
        end else begin
            if (pace_left == 0) begin
                pace_mode = $urandom_range(0, 3);
                pace_left = $urandom_range(16, 128);
            end
            pace_left--;
            case (pace_mode)
                0: stall_next = 1'b0;
                1: stall_next = $urandom_range(0, 9) < 3;
                2: stall_next = $urandom_range(0, 9) < 7;
                default: stall_next = rx_cycle[1];
            endcase
        end
        i_stall <= i_rst_n ? stall_next : 1'b0;
    end

    // Result monitor
    always @(posedge i_clk) begin
        step_result_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_steps.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual pos %0h",
                         $time, o_position);
                errors++;
            end else begin
                want = expected_steps.pop_front();
                cmp_field("status", 32'(want.status), 32'(o_status));
                cmp_field("rate_word", 32'(want.rate), 32'(o_rate_word));
                cmp_field("step_count", 32'(want.steps), 32'(o_step_count));
                cmp_field("counter_clockwise", 32'(want.ccw), 32'(o_counter_clockwise));
                cmp_field("step_word_valid", 32'(want.word_valid), 32'(o_step_word_valid));
                cmp_field("busy", 32'(want.busy), 32'(o_busy_res));
                cmp_field("last_chunk", 32'(want.last), 32'(o_last_chunk));
                cmp_field("position", want.pos, 32'(o_position));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        build_directed();
        build_random(pending_reqs.size() + N_RANDOM);
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (pending_reqs.size() > 0 || i_valid || expected_steps.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (expected_steps.size() != 0) begin
            $display("%0t: %0d results still outstanding", $time, expected_steps.size());
            errors++;
        end
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/lsms_pkg.sv
hdl/lens_stepper_move_sequencer.sv
hdl/lsms_checker.sv
verif/tb.sv
